// ===== src/tlsa_pkg.sv =====
// Shared types and constants for the tree leaf split augmenter.
// Used by tlsa_mem, tlsa_ctrl and tree_leaf_split_augmenter.
`timescale 1ns / 1ps
package tlsa_pkg;

   localparam int MAX_NODES_DEF    = 1024;
   localparam int MAX_FEATURES_DEF = 64;

   localparam logic [2:0] OP_WRITE_NODE    = 3'd0;
   localparam logic [2:0] OP_WRITE_FEATURE = 3'd1;
   localparam logic [2:0] OP_EVALUATE      = 3'd2;
   localparam logic [2:0] OP_AUGMENT       = 3'd3;
   localparam logic [2:0] OP_READ_NODE     = 3'd4;
   localparam logic [2:0] OP_CLEAR         = 3'd5;

   localparam logic [1:0] CSR_TARGET_FEATURE = 2'd0;
   localparam logic [1:0] CSR_CUT_POINT      = 2'd1;
   localparam logic [1:0] CSR_QUERY_A        = 2'd2;
   localparam logic [1:0] CSR_QUERY_B        = 2'd3;

   typedef struct packed {
      logic [5:0]         feature;
      logic signed [31:0] threshold;
      logic [9:0]         left;
      logic [9:0]         right;
   } node_type;

   typedef struct packed {
      logic [5:0]         target_feature;
      logic signed [31:0] cut_point;
      logic signed [31:0] query_a;
      logic signed [31:0] query_b;
   } cfg_type;

   typedef struct packed {
      logic [9:0]  node_index;
      node_type    node;
      logic [10:0] table_size;
      logic        overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EV_NODE,
      ST_EV_FEAT,
      ST_AU_RD,
      ST_AU_W1,
      ST_AU_W2
   } state_type;

endpackage

// ===== src/tlsa_mem.sv =====
// Node table, leaf mark bits and sample row memories, with registered read data.
// Depends on tlsa_pkg.
`timescale 1ns / 1ps
module tlsa_mem #(
   parameter int MAX_NODES    = tlsa_pkg::MAX_NODES_DEF,
   parameter int MAX_FEATURES = tlsa_pkg::MAX_FEATURES_DEF,
   localparam int AW  = $clog2(MAX_NODES),
   localparam int FAW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
   input  logic               clock,
   input  logic               node_re,
   input  logic [AW-1:0]      node_raddr,
   output tlsa_pkg::node_type node_rdata,
   output logic               mark_rdata,
   input  logic               node_we,
   input  logic [AW-1:0]      node_waddr,
   input  tlsa_pkg::node_type node_wdata,
   input  logic               mark_we,
   input  logic [AW-1:0]      mark_waddr,
   input  logic               mark_wdata,
   input  logic               samp_re,
   input  logic [FAW-1:0]     samp_raddr,
   output logic [31:0]        samp_rdata,
   input  logic               samp_we,
   input  logic [FAW-1:0]     samp_waddr,
   input  logic [31:0]        samp_wdata
);

   tlsa_pkg::node_type node_mem [MAX_NODES];
   logic               mark_mem [MAX_NODES];
   logic [31:0]        samp_mem [MAX_FEATURES];

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      if (node_re) begin
         node_rdata <= node_mem[node_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
      if (node_re) begin
         mark_rdata <= mark_mem[node_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (samp_we) begin
         samp_mem[samp_waddr] <= samp_wdata;
      end
      if (samp_re) begin
         samp_rdata <= samp_mem[samp_raddr];
      end
   end

endmodule

// ===== src/tlsa_ctrl.sv =====
// Sequencer: item decode, tree walks, augment sweep, mark clearing, result register.
// Depends on tlsa_pkg; drives the ports of tlsa_mem.
`timescale 1ns / 1ps
module tlsa_ctrl #(
   parameter int MAX_NODES    = tlsa_pkg::MAX_NODES_DEF,
   parameter int MAX_FEATURES = tlsa_pkg::MAX_FEATURES_DEF,
   localparam int AW  = $clog2(MAX_NODES),
   localparam int FAW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
   localparam int CW  = $clog2(MAX_NODES + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  tlsa_pkg::cfg_type  cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_op,
   input  logic [9:0]         req_node_index,
   input  logic [5:0]         req_split_feature,
   input  logic [31:0]        req_split_value,
   input  logic [9:0]         req_left_child,
   input  logic [9:0]         req_right_child,
   input  logic [5:0]         req_feature_index,
   input  logic [31:0]        req_feature_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tlsa_pkg::rsp_type  rsp_data,
   output logic               node_re,
   output logic [AW-1:0]      node_raddr,
   input  tlsa_pkg::node_type node_rdata,
   input  logic               mark_rdata,
   output logic               node_we,
   output logic [AW-1:0]      node_waddr,
   output tlsa_pkg::node_type node_wdata,
   output logic               mark_we,
   output logic [AW-1:0]      mark_waddr,
   output logic               mark_wdata,
   output logic               samp_re,
   output logic [FAW-1:0]     samp_raddr,
   input  logic [31:0]        samp_rdata,
   output logic               samp_we,
   output logic [FAW-1:0]     samp_waddr,
   output logic [31:0]        samp_wdata
);

   localparam logic [AW-1:0] LAST_IDX = AW'(MAX_NODES - 1);

   tlsa_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       cur_ff, cur_in;
   logic [CW-1:0]       steps_ff, steps_in;
   logic                walk_b_ff, walk_b_in;
   logic [AW-1:0]       leaf_a_ff, leaf_a_in;
   tlsa_pkg::node_type  nd_ff, nd_in;
   logic [9:0]          ni_ff, ni_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       orig_ff, orig_in;
   logic                ovf_ff, ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tlsa_pkg::rsp_type   rsp_ff, rsp_in;

   logic               accept;
   logic               is_leaf;
   logic               steps_done;
   logic               is_last;
   logic signed [31:0] x_val;
   logic               take_left;
   logic [9:0]         next_idx;
   logic               next_bad;
   logic               aug_cond;
   logic               aug_room;
   logic               rsp_load;
   logic               ni_ok;

   assign accept     = req_valid && !req_stall;
   assign is_leaf    = (node_rdata.left == 10'd0) && (node_rdata.right == 10'd0);
   assign steps_done = (steps_ff == CW'(MAX_NODES));
   assign is_last    = (cur_ff == LAST_IDX);
   assign ni_ok      = (32'(ni_ff) < MAX_NODES);

   always_comb begin
      if (nd_ff.feature == cfg.target_feature) begin
         x_val = walk_b_ff ? cfg.query_b : cfg.query_a;
      end else if (32'(nd_ff.feature) < MAX_FEATURES) begin
         x_val = $signed(samp_rdata);
      end else begin
         x_val = '0;
      end
   end

   assign take_left = (x_val <= nd_ff.threshold);
   assign next_idx  = take_left ? nd_ff.left : nd_ff.right;
   assign next_bad  = (32'(next_idx) >= MAX_NODES);
   assign aug_cond  = mark_rdata && (CW'(cur_ff) < orig_ff) && is_leaf;
   assign aug_room  = ((CW+1)'(count_ff) + (CW+1)'(2)) <= (CW+1)'(MAX_NODES);
   assign rsp_load  = (state_ff == tlsa_pkg::ST_READ) && (!rsp_valid_ff || !rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlsa_pkg::ST_CLEAR: begin
            if (is_last) state_in = tlsa_pkg::ST_IDLE;
         end
         tlsa_pkg::ST_IDLE: begin
            if (accept) begin
               priority case (req_op)
                  tlsa_pkg::OP_READ_NODE: state_in = tlsa_pkg::ST_READ;
                  tlsa_pkg::OP_EVALUATE:  state_in = tlsa_pkg::ST_EV_NODE;
                  tlsa_pkg::OP_AUGMENT:   state_in = tlsa_pkg::ST_AU_RD;
                  tlsa_pkg::OP_CLEAR:     state_in = tlsa_pkg::ST_CLEAR;
                  default:                state_in = tlsa_pkg::ST_IDLE;
               endcase
            end
         end
         tlsa_pkg::ST_READ: begin
            if (rsp_load) state_in = tlsa_pkg::ST_IDLE;
         end
         tlsa_pkg::ST_EV_NODE: begin
            if (steps_done) begin
               state_in = tlsa_pkg::ST_IDLE;
            end else if (is_leaf) begin
               state_in = walk_b_ff ? tlsa_pkg::ST_IDLE : tlsa_pkg::ST_EV_NODE;
            end else begin
               state_in = tlsa_pkg::ST_EV_FEAT;
            end
         end
         tlsa_pkg::ST_EV_FEAT: begin
            state_in = next_bad ? tlsa_pkg::ST_IDLE : tlsa_pkg::ST_EV_NODE;
         end
         tlsa_pkg::ST_AU_RD: begin
            if (aug_cond && aug_room) begin
               state_in = tlsa_pkg::ST_AU_W1;
            end else if (is_last) begin
               state_in = tlsa_pkg::ST_IDLE;
            end
         end
         tlsa_pkg::ST_AU_W1: state_in = tlsa_pkg::ST_AU_W2;
         tlsa_pkg::ST_AU_W2: begin
            state_in = is_last ? tlsa_pkg::ST_IDLE : tlsa_pkg::ST_AU_RD;
         end
         default: state_in = tlsa_pkg::ST_IDLE;
      endcase
   end

   // memory controls
   always_comb begin
      req_stall  = (state_ff != tlsa_pkg::ST_IDLE);
      node_re    = 1'b0;
      node_raddr = '0;
      node_we    = 1'b0;
      node_waddr = '0;
      node_wdata = '0;
      mark_we    = 1'b0;
      mark_waddr = cur_ff;
      mark_wdata = 1'b0;
      samp_re    = 1'b0;
      samp_raddr = FAW'(node_rdata.feature);
      samp_we    = 1'b0;
      samp_waddr = FAW'(req_feature_index);
      samp_wdata = req_feature_value;
      unique case (state_ff)
         tlsa_pkg::ST_CLEAR: begin
            mark_we = 1'b1;
         end
         tlsa_pkg::ST_IDLE: begin
            if (accept) begin
               priority case (req_op)
                  tlsa_pkg::OP_WRITE_NODE: begin
                     node_we    = (32'(req_node_index) < MAX_NODES);
                     node_waddr = AW'(req_node_index);
                     node_wdata = '{feature: req_split_feature,
                                    threshold: $signed(req_split_value),
                                    left: req_left_child, right: req_right_child};
                  end
                  tlsa_pkg::OP_WRITE_FEATURE: begin
                     samp_we = (32'(req_feature_index) < MAX_FEATURES);
                  end
                  tlsa_pkg::OP_READ_NODE: begin
                     node_re    = 1'b1;
                     node_raddr = AW'(req_node_index);
                  end
                  tlsa_pkg::OP_EVALUATE, tlsa_pkg::OP_AUGMENT: begin
                     node_re    = 1'b1;
                     node_raddr = '0;
                  end
                  default: ;
               endcase
            end
         end
         tlsa_pkg::ST_READ: ;
         tlsa_pkg::ST_EV_NODE: begin
            if (!steps_done) begin
               if (is_leaf) begin
                  if (walk_b_ff) begin
                     mark_we    = (leaf_a_ff == cur_ff);
                     mark_wdata = 1'b1;
                  end else begin
                     node_re    = 1'b1;
                     node_raddr = '0;
                  end
               end else begin
                  samp_re = 1'b1;
               end
            end
         end
         tlsa_pkg::ST_EV_FEAT: begin
            node_re    = !next_bad;
            node_raddr = AW'(next_idx);
         end
         tlsa_pkg::ST_AU_RD: begin
            mark_we = 1'b1;
            if (aug_cond && aug_room) begin
               node_we    = 1'b1;
               node_waddr = cur_ff;
               node_wdata = '{feature: cfg.target_feature, threshold: cfg.cut_point,
                              left: 10'(count_ff), right: 10'(count_ff + CW'(1))};
            end else if (!is_last) begin
               node_re    = 1'b1;
               node_raddr = cur_ff + AW'(1);
            end
         end
         tlsa_pkg::ST_AU_W1: begin
            node_we    = 1'b1;
            node_waddr = AW'(count_ff);
         end
         tlsa_pkg::ST_AU_W2: begin
            node_we    = 1'b1;
            node_waddr = AW'(count_ff + CW'(1));
            if (!is_last) begin
               node_re    = 1'b1;
               node_raddr = cur_ff + AW'(1);
            end
         end
         default: ;
      endcase
   end

   // datapath registers
   always_comb begin
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      walk_b_in    = walk_b_ff;
      leaf_a_in    = leaf_a_ff;
      nd_in        = nd_ff;
      ni_in        = ni_ff;
      count_in     = count_ff;
      orig_in      = orig_ff;
      ovf_in       = ovf_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         tlsa_pkg::ST_CLEAR: begin
            cur_in = cur_ff + AW'(1);
         end
         tlsa_pkg::ST_IDLE: begin
            if (accept) begin
               ni_in     = req_node_index;
               cur_in    = '0;
               steps_in  = '0;
               walk_b_in = 1'b0;
               orig_in   = count_ff;
               priority case (req_op)
                  tlsa_pkg::OP_WRITE_NODE: begin
                     if ((32'(req_node_index) < MAX_NODES) &&
                         (CW'(req_node_index) + CW'(1) > count_ff)) begin
                        count_in = CW'(req_node_index) + CW'(1);
                     end
                  end
                  tlsa_pkg::OP_CLEAR: begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         tlsa_pkg::ST_READ: begin
            if (rsp_load) begin
               rsp_valid_in       = 1'b1;
               rsp_in.node_index  = ni_ff;
               rsp_in.node        = ni_ok ? node_rdata : '0;
               rsp_in.table_size  = 11'(count_ff);
               rsp_in.overflow    = ovf_ff;
            end
         end
         tlsa_pkg::ST_EV_NODE: begin
            nd_in = node_rdata;
            if (is_leaf && !walk_b_ff) begin
               leaf_a_in = cur_ff;
               walk_b_in = 1'b1;
               cur_in    = '0;
               steps_in  = '0;
            end
         end
         tlsa_pkg::ST_EV_FEAT: begin
            cur_in   = AW'(next_idx);
            steps_in = steps_ff + CW'(1);
         end
         tlsa_pkg::ST_AU_RD: begin
            if (aug_cond && !aug_room) begin
               ovf_in = 1'b1;
            end
            if (!(aug_cond && aug_room) && !is_last) begin
               cur_in = cur_ff + AW'(1);
            end
         end
         tlsa_pkg::ST_AU_W1: ;
         tlsa_pkg::ST_AU_W2: begin
            count_in = count_ff + CW'(2);
            cur_in   = cur_ff + AW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlsa_pkg::ST_CLEAR;
         cur_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff  <= steps_in;
      walk_b_ff <= walk_b_in;
      leaf_a_ff <= leaf_a_in;
      nd_ff     <= nd_in;
      ni_ff     <= ni_in;
      orig_ff   <= orig_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/tree_leaf_split_augmenter.sv =====
// Top level of the tree leaf split augmenter: configuration registers and wiring.
// Depends on tlsa_pkg, tlsa_mem and tlsa_ctrl.
//
// Usage: items enter on req_* (valid/stall) and read results leave on rsp_*
// (valid/stall); configuration registers are written on csr_* (valid/ready,
// always ready); the user must write them only while the block is idle, which the
// block itself does not enforce. Only a read node item gives a result.
// A node or feature write is done when accepted; a read then loads the result
// register, waiting while a pending result is held by rsp_stall. An evaluate item
// is accepted, then on each of its two walks makes one node memory read and then
// one sample memory read per inner node visited, and then checks the leaf. An
// augment item sweeps every table entry and writes two child nodes for each leaf
// that is split. A clear item runs the mark sweep over every entry. After reset
// the same mark sweep runs, during which req_stall stays high. A pending result
// holds its payload while rsp_stall is high; the block can take the next item
// meanwhile, and a following read waits until the result register is free.
`timescale 1ns / 1ps
module tree_leaf_split_augmenter #(
   parameter int MAX_NODES    = tlsa_pkg::MAX_NODES_DEF,
   parameter int MAX_FEATURES = tlsa_pkg::MAX_FEATURES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [9:0]  req_node_index,
   input  logic [5:0]  req_split_feature,
   input  logic [31:0] req_split_value,
   input  logic [9:0]  req_left_child,
   input  logic [9:0]  req_right_child,
   input  logic [5:0]  req_feature_index,
   input  logic [31:0] req_feature_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_out_node_index,
   output logic [5:0]  rsp_out_split_feature,
   output logic [31:0] rsp_out_split_value,
   output logic [9:0]  rsp_out_left_child,
   output logic [9:0]  rsp_out_right_child,
   output logic [10:0] rsp_table_size,
   output logic        rsp_overflow,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int AW  = $clog2(MAX_NODES);
   localparam int FAW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

   tlsa_pkg::cfg_type  cfg_ff, cfg_in;
   tlsa_pkg::rsp_type  rsp_data;
   tlsa_pkg::node_type node_rdata;
   tlsa_pkg::node_type node_wdata;
   logic               node_re, node_we, mark_rdata, mark_we, mark_wdata;
   logic               samp_re, samp_we;
   logic [AW-1:0]      node_raddr, node_waddr, mark_waddr;
   logic [FAW-1:0]     samp_raddr, samp_waddr;
   logic [31:0]        samp_rdata, samp_wdata;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tlsa_pkg::CSR_TARGET_FEATURE: cfg_in.target_feature = csr_wdata[5:0];
            tlsa_pkg::CSR_CUT_POINT:      cfg_in.cut_point      = $signed(csr_wdata);
            tlsa_pkg::CSR_QUERY_A:        cfg_in.query_a        = $signed(csr_wdata);
            tlsa_pkg::CSR_QUERY_B:        cfg_in.query_b        = $signed(csr_wdata);
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{target_feature: 6'd0, cut_point: 32'sd32768,
                     query_a: 32'sd0, query_b: 32'sd65536};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tlsa_mem #(
      .MAX_NODES(MAX_NODES),
      .MAX_FEATURES(MAX_FEATURES)
   ) u_mem (
      .clock(clock),
      .node_re(node_re),
      .node_raddr(node_raddr),
      .node_rdata(node_rdata),
      .mark_rdata(mark_rdata),
      .node_we(node_we),
      .node_waddr(node_waddr),
      .node_wdata(node_wdata),
      .mark_we(mark_we),
      .mark_waddr(mark_waddr),
      .mark_wdata(mark_wdata),
      .samp_re(samp_re),
      .samp_raddr(samp_raddr),
      .samp_rdata(samp_rdata),
      .samp_we(samp_we),
      .samp_waddr(samp_waddr),
      .samp_wdata(samp_wdata)
   );

   tlsa_ctrl #(
      .MAX_NODES(MAX_NODES),
      .MAX_FEATURES(MAX_FEATURES)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_node_index(req_node_index),
      .req_split_feature(req_split_feature),
      .req_split_value(req_split_value),
      .req_left_child(req_left_child),
      .req_right_child(req_right_child),
      .req_feature_index(req_feature_index),
      .req_feature_value(req_feature_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .node_re(node_re),
      .node_raddr(node_raddr),
      .node_rdata(node_rdata),
      .mark_rdata(mark_rdata),
      .node_we(node_we),
      .node_waddr(node_waddr),
      .node_wdata(node_wdata),
      .mark_we(mark_we),
      .mark_waddr(mark_waddr),
      .mark_wdata(mark_wdata),
      .samp_re(samp_re),
      .samp_raddr(samp_raddr),
      .samp_rdata(samp_rdata),
      .samp_we(samp_we),
      .samp_waddr(samp_waddr),
      .samp_wdata(samp_wdata)
   );

   assign rsp_out_node_index    = rsp_data.node_index;
   assign rsp_out_split_feature = rsp_data.node.feature;
   assign rsp_out_split_value   = rsp_data.node.threshold;
   assign rsp_out_left_child    = rsp_data.node.left;
   assign rsp_out_right_child   = rsp_data.node.right;
   assign rsp_table_size        = rsp_data.table_size;
   assign rsp_overflow          = rsp_data.overflow;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for tree_leaf_split_augmenter: directed table, then random
// tree build / evaluate / augment / read episodes, checked by an in-bench predictor or the table.
// Depends on tlsa_pkg and the tree_leaf_split_augmenter RTL.
`timescale 1ns / 1ps
module tb;

   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
   localparam int NODES   = 1024;
   localparam int FEATS   = 64;
   localparam int SETTLE  = 4400;
   localparam int LIMIT   = 40000000;
   localparam int N_ITEMS = 1850;

   typedef struct {
      logic [2:0]  op;
      logic [9:0]  ni;
      logic [5:0]  sf;
      logic [31:0] sv;
      logic [9:0]  lc;
      logic [9:0]  rc;
      logic [5:0]  fi;
      logic [31:0] fv;
   } tree_cmd_type;

   typedef struct {
      logic [9:0]  idx;
      logic [5:0]  f;
      logic [31:0] v;
      logic [9:0]  l;
      logic [9:0]  r;
      logic [10:0] size;
      logic        ovf;
   } node_report_type;

   typedef struct {
      tree_cmd_type    cmd;
      bit              typed;
      node_report_type want;
   } table_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_op = 0;
   logic [9:0]  req_node_index = 0;
   logic [5:0]  req_split_feature = 0;
   logic [31:0] req_split_value = 0;
   logic [9:0]  req_left_child = 0;
   logic [9:0]  req_right_child = 0;
   logic [5:0]  req_feature_index = 0;
   logic [31:0] req_feature_value = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [9:0]  rsp_out_node_index;
   logic [5:0]  rsp_out_split_feature;
   logic [31:0] rsp_out_split_value;
   logic [9:0]  rsp_out_left_child;
   logic [9:0]  rsp_out_right_child;
   logic [10:0] rsp_table_size;
   logic        rsp_overflow;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = 0;
   logic [31:0] csr_wdata = 0;

   tree_leaf_split_augmenter DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_node_index(req_node_index), .req_split_feature(req_split_feature),
      .req_split_value(req_split_value), .req_left_child(req_left_child),
      .req_right_child(req_right_child), .req_feature_index(req_feature_index),
      .req_feature_value(req_feature_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_node_index(rsp_out_node_index),
      .rsp_out_split_feature(rsp_out_split_feature),
      .rsp_out_split_value(rsp_out_split_value),
      .rsp_out_left_child(rsp_out_left_child),
      .rsp_out_right_child(rsp_out_right_child),
      .rsp_table_size(rsp_table_size), .rsp_overflow(rsp_overflow),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [5:0]         m_feat [NODES];
   logic signed [31:0] m_thr [NODES];
   logic [9:0]         m_left [NODES];
   logic [9:0]         m_right [NODES];
   bit                 m_written [NODES];
   bit                 m_mark [NODES];
   logic signed [31:0] m_row [FEATS];
   int                 m_count = 0;
   bit                 m_ovf = 0;
   logic [5:0]         c_target = 0;
   logic signed [31:0] c_cut = 32768;
   logic signed [31:0] c_qa = 0;
   logic signed [31:0] c_qb = 65536;

   node_report_type pending_reads[$];
   int fails = 0;
   int sent = 0;
   int cycles = 0;
   bit quiet = 0;
   table_row_type directed[22];

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 33);
   end

   always @(posedge clock) begin
      node_report_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reads.size() == 0) begin
            $error("unexpected result for node %0d", rsp_out_node_index);
            fails++;
         end else begin
            w = pending_reads.pop_front();
            if (rsp_out_node_index !== w.idx) begin
               $error("out_node_index exp %0d got %0d", w.idx, rsp_out_node_index); fails++;
            end
            if (rsp_out_split_feature !== w.f) begin
               $error("out_split_feature exp %0d got %0d", w.f, rsp_out_split_feature);
               fails++;
            end
            if (rsp_out_split_value !== w.v) begin
               $error("out_split_value exp %h got %h", w.v, rsp_out_split_value); fails++;
            end
            if (rsp_out_left_child !== w.l) begin
               $error("out_left_child exp %0d got %0d", w.l, rsp_out_left_child); fails++;
            end
            if (rsp_out_right_child !== w.r) begin
               $error("out_right_child exp %0d got %0d", w.r, rsp_out_right_child); fails++;
            end
            if (rsp_table_size !== w.size) begin
               $error("table_size exp %0d got %0d", w.size, rsp_table_size); fails++;
            end
            if (rsp_overflow !== w.ovf) begin
               $error("overflow exp %0d got %0d", w.ovf, rsp_overflow); fails++;
            end
         end
      end
   end

   // unsafe: the walk would touch a node never written
   function automatic bit walk_tree(input logic signed [31:0] q, output int leaf,
                                    output bit unsafe);
      int n;
      logic signed [31:0] x;
      n = 0;
      unsafe = 0;
      leaf = 0;
      for (int steps = 0; steps < NODES; steps++) begin
         if (!m_written[n]) begin
            unsafe = 1;
            return 0;
         end
         if (m_left[n] == 0 && m_right[n] == 0) begin
            leaf = n;
            return 1;
         end
         x = (m_feat[n] == c_target) ? q : m_row[m_feat[n]];
         n = (x <= m_thr[n]) ? m_left[n] : m_right[n];
      end
      return 0;
   endfunction

   function automatic bit evaluate_is_safe();
      int la, lb;
      bit ua, ub;
      void'(walk_tree(c_qa, la, ua));
      void'(walk_tree(c_qb, lb, ub));
      return !ua && !ub;
   endfunction

   function automatic void split_marked_leaves();
      int orig;
      orig = m_count;
      for (int i = 0; i < NODES; i++) begin
         if (!m_mark[i] || i >= orig || m_left[i] != 0 || m_right[i] != 0) continue;
         if (m_count + 2 > NODES) begin
            m_ovf = 1;
            continue;
         end
         m_feat[i] = c_target;
         m_thr[i] = c_cut;
         m_left[i] = m_count[9:0];
         m_right[i] = 10'(m_count + 1);
         for (int k = m_count; k < m_count + 2; k++) begin
            m_feat[k] = 0;
            m_thr[k] = 0;
            m_left[k] = 0;
            m_right[k] = 0;
            m_written[k] = 1;
         end
         m_count += 2;
      end
      foreach (m_mark[i]) m_mark[i] = 0;
   endfunction

   function automatic bit predict_item(input tree_cmd_type c, output node_report_type rep);
      int la, lb;
      bit ua, ub;
      rep = '{default: 0};
      case (c.op)
         tlsa_pkg::OP_WRITE_NODE: begin
            m_feat[c.ni] = c.sf;
            m_thr[c.ni] = c.sv;
            m_left[c.ni] = c.lc;
            m_right[c.ni] = c.rc;
            m_written[c.ni] = 1;
            if (c.ni + 1 > m_count) m_count = c.ni + 1;
         end
         tlsa_pkg::OP_WRITE_FEATURE: m_row[c.fi] = c.fv;
         tlsa_pkg::OP_EVALUATE: begin
            if (walk_tree(c_qa, la, ua) && walk_tree(c_qb, lb, ub) && la == lb)
               m_mark[la] = 1;
         end
         tlsa_pkg::OP_AUGMENT: split_marked_leaves();
         tlsa_pkg::OP_READ_NODE: begin
            rep = '{c.ni, m_feat[c.ni], m_thr[c.ni], m_left[c.ni], m_right[c.ni],
                    11'(m_count), m_ovf};
            return 1;
         end
         tlsa_pkg::OP_CLEAR: begin
            m_count = 0;
            m_ovf = 0;
            foreach (m_mark[i]) m_mark[i] = 0;
         end
         default: ;
      endcase
      return 0;
   endfunction

   // called at a falling edge; returns at a falling edge with valid left high
   task automatic send_item(input tree_cmd_type c, input bit typed,
                            input node_report_type want);
      node_report_type rep;
      quiet = (sent >= 700 && sent < 1000);
      if (!quiet && $urandom_range(99) < 33) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1;
      req_op <= c.op;
      req_node_index <= c.ni;
      req_split_feature <= c.sf;
      req_split_value <= c.sv;
      req_left_child <= c.lc;
      req_right_child <= c.rc;
      req_feature_index <= c.fi;
      req_feature_value <= c.fv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (predict_item(c, rep)) begin
         if (typed) rep = want;
         pending_reads = {pending_reads, rep};
      end
      sent++;
      @(negedge clock);
   endtask

   task automatic send_cmd(input tree_cmd_type c);
      send_item(c, 0, '{default: 0});
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         tlsa_pkg::CSR_TARGET_FEATURE: c_target = data[5:0];
         tlsa_pkg::CSR_CUT_POINT:      c_cut = data;
         tlsa_pkg::CSR_QUERY_A:        c_qa = data;
         tlsa_pkg::CSR_QUERY_B:        c_qb = data;
      endcase
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(4))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom;
         default: return 32'($signed($urandom_range(0, 6 * 65536)) - 3 * 65536);
      endcase
   endfunction

   task automatic set_config(input int ep);
      logic [5:0] tf;
      wait_idle();
      tf = (ep % 8 == 1) ? 6'd63 : (ep % 8 == 2) ? 6'd0 : 6'($urandom_range(0, 7));
      write_reg(tlsa_pkg::CSR_TARGET_FEATURE, {26'd0, tf});
      write_reg(tlsa_pkg::CSR_CUT_POINT, pick_word());
      write_reg(tlsa_pkg::CSR_QUERY_A, pick_word());
      write_reg(tlsa_pkg::CSR_QUERY_B, pick_word());
      csr_valid <= 0;
   endtask

   function automatic tree_cmd_type rand_cmd();
      tree_cmd_type c;
      c.op = 3'($urandom);
      c.ni = 10'($urandom);
      c.sf = 6'($urandom);
      c.sv = $urandom;
      c.lc = 10'($urandom);
      c.rc = 10'($urandom);
      c.fi = 6'($urandom);
      c.fv = $urandom;
      return c;
   endfunction

   function automatic logic [31:0] pick_split();
      case ($urandom_range(5))
         0: return c_qa;
         1: return c_qb;
         2: return c_qa - 1;
         3: return c_qb - 1;
         4: return c_cut;
         default: return pick_word();
      endcase
   endfunction

   function automatic logic [9:0] pick_written();
      int n;
      for (int t = 0; t < 20; t++) begin
         n = (m_count > 0 && $urandom_range(3) != 0) ? $urandom_range(0, m_count - 1)
                                                    : $urandom_range(0, NODES - 1);
         if (m_written[n]) return 10'(n);
      end
      return 10'd0;
   endfunction

   task automatic run_episode();
      tree_cmd_type c;
      int n;
      c = rand_cmd();
      c.op = tlsa_pkg::OP_CLEAR;
      send_cmd(c);
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         c = rand_cmd();
         c.op = tlsa_pkg::OP_WRITE_NODE;
         c.ni = 10'(i);
         c.sf = $urandom_range(1) ? c_target : 6'($urandom_range(0, 63));
         c.sv = pick_split();
         if (i == n - 1 || $urandom_range(99) < 30) begin
            c.lc = 0;
            c.rc = 0;
         end else begin
            c.lc = 10'($urandom_range(i + 1, n - 1));
            c.rc = 10'($urandom_range(i + 1, n - 1));
         end
         // broken tree: a back edge may make a loop
         if ($urandom_range(99) < 5) c.lc = 10'($urandom_range(0, n - 1));
         send_cmd(c);
      end
      if ($urandom_range(5) == 0) begin
         c = rand_cmd();
         c.op = tlsa_pkg::OP_WRITE_NODE;
         c.ni = 10'($urandom_range(1018, 1023));
         c.lc = 0;
         c.rc = 0;
         send_cmd(c);
      end
      repeat ($urandom_range(2, 8)) begin
         c = rand_cmd();
         case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: c.op = tlsa_pkg::OP_EVALUATE;
            12, 13, 14, 15, 16: c.op = tlsa_pkg::OP_WRITE_FEATURE;
            default: ;
         endcase
         if (c.op == tlsa_pkg::OP_READ_NODE) c.ni = pick_written();
         if (c.op == tlsa_pkg::OP_EVALUATE && !evaluate_is_safe()) begin
            c.op = tlsa_pkg::OP_READ_NODE;
            c.ni = pick_written();
         end
         send_cmd(c);
      end
      if ($urandom_range(9) != 0) begin
         c = rand_cmd();
         c.op = tlsa_pkg::OP_AUGMENT;
         send_cmd(c);
      end
      repeat ($urandom_range(1, 4)) begin
         c = rand_cmd();
         c.op = tlsa_pkg::OP_READ_NODE;
         c.ni = pick_written();
         send_cmd(c);
      end
   endtask

   initial begin
      tree_cmd_type c;
      int ep;
      node_report_type none;
      none = '{default: 0};
      foreach (m_written[i]) begin
         m_written[i] = 0;
         m_mark[i] = 0;
      end
      directed[0]  = '{'{tlsa_pkg::OP_WRITE_NODE, 10'd0, 6'd63, 32'h8000_0000, 10'd0, 10'd0,
                         6'd0, 32'd0}, 0, none};
      directed[1]  = '{'{tlsa_pkg::OP_READ_NODE, 10'd0, 6'd0, 32'd0, 10'd0, 10'd0,
                         6'd0, 32'd0},
                       1, '{10'd0, 6'd63, 32'h8000_0000, 10'd0, 10'd0, 11'd1, 1'b0}};
      directed[2]  = '{'{tlsa_pkg::OP_WRITE_NODE, 10'd1023, 6'd0, 32'h7fff_ffff, 10'h3ff,
                         10'h3ff, 6'd63, 32'hffff_ffff}, 0, none};
      directed[3]  = '{'{tlsa_pkg::OP_READ_NODE, 10'd1023, 6'd0, 32'd0, 10'd0, 10'd0,
                         6'd0, 32'd0},
                       1, '{10'd1023, 6'd0, 32'h7fff_ffff, 10'h3ff, 10'h3ff, 11'd1024, 1'b0}};
      directed[4]  = '{'{tlsa_pkg::OP_WRITE_FEATURE, 10'd0, 6'd0, 32'd0, 10'd0, 10'd0,
                         6'd63, 32'h8000_0000}, 0, none};
      directed[5]  = '{'{tlsa_pkg::OP_WRITE_FEATURE, 10'd0, 6'd0, 32'd0, 10'd0, 10'd0,
                         6'd0, 32'h7fff_ffff}, 0, none};
      directed[6]  = '{'{tlsa_pkg::OP_EVALUATE, 10'd0, 6'd0, 32'd0, 10'd0, 10'd0,
                         6'd0, 32'd0}, 0, none};
      // full table: the marked root cannot be split
      directed[7]  = '{'{tlsa_pkg::OP_AUGMENT, 10'd0, 6'd0, 32'd0, 10'd0, 10'd0,
                         6'd0, 32'd0}, 0, none};
      directed[8]  = '{'{tlsa_pkg::OP_READ_NODE, 10'd0, 6'd0, 32'd0, 10'd0, 10'd0,
                         6'd0, 32'd0},
                       1, '{10'd0, 6'd63, 32'h8000_0000, 10'd0, 10'd0, 11'd1024, 1'b1}};
      directed[9]  = '{'{tlsa_pkg::OP_CLEAR, 10'd0, 6'd0, 32'd0, 10'd0, 10'd0,
                         6'd0, 32'd0}, 0, none};
      directed[10] = '{'{tlsa_pkg::OP_READ_NODE, 10'd0, 6'd0, 32'd0, 10'd0, 10'd0,
                         6'd0, 32'd0},
                       1, '{10'd0, 6'd63, 32'h8000_0000, 10'd0, 10'd0, 11'd0, 1'b0}};
      // empty table: the mark lies beyond the size and is dropped
      directed[11] = '{'{tlsa_pkg::OP_EVALUATE, 10'd0, 6'd0, 32'd0, 10'd0, 10'd0,
                         6'd0, 32'd0}, 0, none};
      directed[12] = '{'{tlsa_pkg::OP_AUGMENT, 10'd0, 6'd0, 32'd0, 10'd0, 10'd0,
                         6'd0, 32'd0}, 0, none};
      directed[13] = directed[10];
      directed[14] = directed[0];
      directed[15] = directed[6];
      directed[16] = directed[7];
      directed[17] = '{'{tlsa_pkg::OP_READ_NODE, 10'd0, 6'd0, 32'd0, 10'd0, 10'd0,
                         6'd0, 32'd0},
                       1, '{10'd0, 6'd0, 32'd32768, 10'd1, 10'd2, 11'd3, 1'b0}};
      directed[18] = '{'{tlsa_pkg::OP_READ_NODE, 10'd2, 6'd0, 32'd0, 10'd0, 10'd0,
                         6'd0, 32'd0},
                       1, '{10'd2, 6'd0, 32'd0, 10'd0, 10'd0, 11'd3, 1'b0}};
      directed[19] = '{'{OP_SPARE_6, 10'h3ff, 6'h3f, 32'hffff_ffff, 10'h3ff, 10'h3ff, 6'h3f,
                         32'hffff_ffff}, 0, none};
      directed[20] = '{'{OP_SPARE_7, 10'd0, 6'd0, 32'd0, 10'd0, 10'd0, 6'd0, 32'd0}, 0, none};
      directed[21] = '{'{tlsa_pkg::OP_READ_NODE, 10'd1, 6'd0, 32'd0, 10'd0, 10'd0,
                         6'd0, 32'd0},
                       1, '{10'd1, 6'd0, 32'd0, 10'd0, 10'd0, 11'd3, 1'b0}};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // whole sample row defined before any walk
      for (int f = 0; f < FEATS; f++) begin
         c = rand_cmd();
         c.op = tlsa_pkg::OP_WRITE_FEATURE;
         c.fi = 6'(f);
         send_cmd(c);
      end
      foreach (directed[i]) send_item(directed[i].cmd, directed[i].typed, directed[i].want);

      ep = 0;
      while (sent < N_ITEMS) begin
         if (ep % 4 == 1) set_config(ep);
         run_episode();
         ep++;
      end

      req_valid <= 0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fails == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
